/* hw/rtl/aclr_pkg.sv */
// Package: parse state codes, result codes and keyword table for the command line recognizer.
`default_nettype none
package aclr_pkg;

   localparam int StateWidth = 5;
   localparam int CharWidth  = 8;
   localparam int KindWidth  = 2;
   localparam int CodeWidth  = 3;
   localparam int DataWidth  = 16;

   typedef logic [StateWidth-1:0] state_type;
   typedef logic [CharWidth-1:0]  char_type;
   typedef logic [KindWidth-1:0]  kind_type;
   typedef logic [CodeWidth-1:0]  code_type;

   localparam state_type ST_BEGIN  = 5'd0;
   localparam state_type ST_L      = 5'd1;
   localparam state_type ST_LOGOUT = 5'd6;
   localparam state_type ST_S      = 5'd7;
   localparam state_type ST_ST     = 5'd8;
   localparam state_type ST_STATS  = 5'd11;
   localparam state_type ST_SE     = 5'd12;
   localparam state_type ST_SETCMD = 5'd16;
   localparam state_type ST_G      = 5'd17;
   localparam state_type ST_GETCMD = 5'd22;
   localparam state_type ST_H      = 5'd23;
   localparam state_type ST_HELP   = 5'd26;
   localparam state_type ST_ARGS   = 5'd27;
   localparam state_type ST_BAD    = 5'd28;

   localparam char_type CH_NL    = 8'h0A;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_L     = 8'h4C;
   localparam char_type CH_S     = 8'h53;
   localparam char_type CH_G     = 8'h47;
   localparam char_type CH_H     = 8'h48;
   localparam char_type CH_T     = 8'h54;
   localparam char_type CH_E     = 8'h45;

   localparam kind_type KIND_ARG     = 2'd0;
   localparam kind_type KIND_CMD     = 2'd1;
   localparam kind_type KIND_INVALID = 2'd2;

   localparam code_type CMD_STATS  = 3'd0;
   localparam code_type CMD_GETCMD = 3'd1;
   localparam code_type CMD_SETCMD = 3'd2;
   localparam code_type CMD_LOGOUT = 3'd3;
   localparam code_type CMD_HELP   = 3'd4;

   // Result of one parse step.
   typedef struct packed {
      state_type next_state;
      logic      has_result;
      kind_type  kind;
      code_type  code;
      char_type  arg;
   } step_type;

   // Expected upper-case character in the straight runs of each keyword; 0 elsewhere.
   function automatic char_type expect_char(input state_type st);
      char_type ch;
      case (st)
         5'd1:    ch = 8'h4F; // O
         5'd2:    ch = 8'h47; // G
         5'd3:    ch = 8'h4F; // O
         5'd4:    ch = 8'h55; // U
         5'd5:    ch = 8'h54; // T
         5'd8:    ch = 8'h41; // A
         5'd9:    ch = 8'h54; // T
         5'd10:   ch = 8'h53; // S
         5'd12:   ch = 8'h54; // T
         5'd13:   ch = 8'h43; // C
         5'd14:   ch = 8'h4D; // M
         5'd15:   ch = 8'h44; // D
         5'd17:   ch = 8'h45; // E
         5'd18:   ch = 8'h54; // T
         5'd19:   ch = 8'h43; // C
         5'd20:   ch = 8'h4D; // M
         5'd21:   ch = 8'h44; // D
         5'd23:   ch = 8'h45; // E
         5'd24:   ch = 8'h4C; // L
         5'd25:   ch = 8'h50; // P
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/admin_command_line_recognizer_core.sv */
// Top level: input register, parse step, parse state and result register.
//
// Command line recognizer. One ASCII character per transfer on the req_ stream;
// results leave on the rsp_ stream. Keywords STATS, GETCMD, SETCMD, LOGOUT and
// HELP are matched without regard to case; SETCMD takes a space and an argument
// whose characters stream out one per transfer (kind 0). A newline yields the
// command code (kind 1) or one invalid-line result (kind 2).
// Each character is registered first, then its result once the output register
// is free. Characters that give no result only move the parse state. Throughput:
// one character per cycle unless a stalled result holds it; the next character
// is taken while a result waits in the output register, as the input register
// is a stage of its own and the parse state is one register updated per step.
// Reset (synchronous, active high) empties both registers and returns the
// parse to the start of a line.
// When the receiver stalls, the result holds in the output register; one more
// character waits in the input register, then req_tready drops until a
// result is taken. Characters without a result keep flowing past a stall.
`default_nettype none
module admin_command_line_recognizer_core
   import aclr_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire [CharWidth-1:0]  req_tdata,  // [7:0] char_in
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [DataWidth-1:0] rsp_tdata,  // [2:0] command_code, [10:3] arg_char, rest 0
   output logic [KindWidth-1:0] rsp_tuser   // [1:0] result_kind
);

   logic      in_valid_ff, in_valid_in;
   char_type  in_char_ff, in_char_in;
   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   kind_type  out_kind_ff, out_kind_in;
   code_type  out_code_ff, out_code_in;
   char_type  out_arg_ff, out_arg_in;

   step_type step;
   logic     out_free;
   logic     advance;

   aclr_step u_step (
      .st   (state_ff),
      .raw  (in_char_ff),
      .step (step)
   );

   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      advance    = in_valid_ff && (!step.has_result || out_free);
      req_tready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata;
      end

      state_in = advance ? step.next_state : state_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_code_in  = out_code_ff;
      out_arg_in   = out_arg_ff;
      if (advance && step.has_result) begin
         out_valid_in = 1'b1;
         out_kind_in  = step.kind;
         out_code_in  = step.code;
         out_arg_in   = step.arg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= ST_BEGIN;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      in_char_ff  <= in_char_in;
      out_kind_ff <= out_kind_in;
      out_code_ff <= out_code_in;
      out_arg_ff  <= out_arg_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {{(DataWidth - CodeWidth - CharWidth){1'b0}}, out_arg_ff, out_code_ff};

`ifndef SYNTHESIS
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_BAD)
      else $error("parse state out of range");

   a_newline_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && in_char_ff == CH_NL) |=> (state_ff == ST_BEGIN && out_valid_ff))
      else $error("newline did not restart parse with a result");

   a_arg_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_ARG) |-> (out_code_ff == CMD_STATS))
      else $error("argument result with nonzero command code");

   a_cmd_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff != KIND_ARG) |-> (out_arg_ff == 8'h00))
      else $error("command result with nonzero argument");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_kind_ff)
                                          && $stable(out_arg_ff)))
      else $error("stalled result overwritten");
`endif

endmodule
`default_nettype wire

/* hw/rtl/aclr_step.sv */
// One parse step: next state and result for one character in the current state.
`default_nettype none
module aclr_step
   import aclr_pkg::*;
(
   input  wire state_type st,
   input  wire char_type  raw,
   output step_type       step
);

   char_type up;
   char_type exp_ch;

   always_comb begin
      up     = (raw inside {[8'h61:8'h7A]}) ? (raw - 8'h20) : raw;
      exp_ch = expect_char(st);

      step            = '0;
      step.next_state = ST_BAD;

      if (raw == CH_NL) begin
         step.next_state = ST_BEGIN;
         step.has_result = 1'b1;
         step.kind       = KIND_CMD;
         case (st)
            ST_STATS:  step.code = CMD_STATS;
            ST_GETCMD: step.code = CMD_GETCMD;
            ST_ARGS:   step.code = CMD_SETCMD;
            ST_LOGOUT: step.code = CMD_LOGOUT;
            ST_HELP:   step.code = CMD_HELP;
            default:   step.kind = KIND_INVALID;
         endcase
      end else if (st == ST_ARGS) begin
         step.next_state = ST_ARGS;
         step.has_result = 1'b1;
         step.kind       = KIND_ARG;
         step.arg        = raw;
      end else if (st == ST_BEGIN) begin
         if (up == CH_L)      step.next_state = ST_L;
         else if (up == CH_S) step.next_state = ST_S;
         else if (up == CH_G) step.next_state = ST_G;
         else if (up == CH_H) step.next_state = ST_H;
      end else if (st == ST_S) begin
         if (up == CH_T)      step.next_state = ST_ST;
         else if (up == CH_E) step.next_state = ST_SE;
      end else if (st == ST_SETCMD) begin
         if (raw == CH_SPACE) step.next_state = ST_ARGS;
      end else if (exp_ch != 8'h00 && up == exp_ch) begin
         step.next_state = st + 5'd1;
      end
   end

endmodule
`default_nettype wire

/* verif/admin_command_line_recognizer_core_tb.sv */
// Testbench for the command line recognizer: random character stream, scoreboard check.
`timescale 1ns / 100ps

module admin_command_line_recognizer_core_tb;
   import aclr_pkg::*;

   localparam int TailChars  = 40;
   localparam int CycleLimit = 200000;
   localparam int LongHold   = 300;

   typedef struct {
      kind_type kind;
      code_type code;
      char_type arg;
   } outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [CharWidth-1:0] req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DataWidth-1:0] rsp_tdata;
   logic [KindWidth-1:0] rsp_tuser;

   char_type    line_chars[$];
   outcome_type pending_results[$];
   state_type   line_state = ST_BEGIN;
   bit          char_taken = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          long_hold_done = 1'b0;
   int          results_taken = 0;
   int          errors = 0;
   int          cycles = 0;
   string       kw_logout = "LOGOUT";
   string       kw_stats  = "STATS";
   string       kw_setcmd = "SETCMD";
   string       kw_getcmd = "GETCMD";
   string       kw_help   = "HELP";

   admin_command_line_recognizer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Upper-case letter awaited in the straight part of a keyword; 0 outside those runs.
   function automatic char_type keyword_letter(input state_type st);
      int s;
      s = int'(st);
      if (s >= int'(ST_L) && s < int'(ST_LOGOUT))
         return char_type'(kw_logout[s - int'(ST_L) + 1]);
      if (s >= int'(ST_ST) && s < int'(ST_STATS))
         return char_type'(kw_stats[s - int'(ST_S) + 1]);
      if (s >= int'(ST_SE) && s < int'(ST_SETCMD))
         return char_type'(kw_setcmd[s - int'(ST_SE) + 2]);
      if (s >= int'(ST_G) && s < int'(ST_GETCMD))
         return char_type'(kw_getcmd[s - int'(ST_G) + 1]);
      if (s >= int'(ST_H) && s < int'(ST_HELP))
         return char_type'(kw_help[s - int'(ST_H) + 1]);
      return '0;
   endfunction

   // Advances the line parse by one character; returns 1 when a result is due.
   function automatic bit parse_char(input char_type c, output outcome_type r);
      state_type st;
      char_type  up;
      char_type  want;
      bit        has;
      st  = line_state;
      up  = (c >= "a" && c <= "z") ? c - 8'h20 : c;
      r   = '{kind: KIND_ARG, code: CMD_STATS, arg: '0};
      has = 1'b0;
      if (c == CH_NL) begin
         has = 1'b1;
         r.kind = KIND_CMD;
         case (st)
            ST_STATS:  r.code = CMD_STATS;
            ST_GETCMD: r.code = CMD_GETCMD;
            ST_ARGS:   r.code = CMD_SETCMD;
            ST_LOGOUT: r.code = CMD_LOGOUT;
            ST_HELP:   r.code = CMD_HELP;
            default:   r.kind = KIND_INVALID;
         endcase
         st = ST_BEGIN;
      end else if (st == ST_ARGS) begin
         has = 1'b1;
         r.arg = c;
      end else begin
         want = keyword_letter(st);
         if (st == ST_BEGIN) begin
            case (up)
               CH_L:    st = ST_L;
               CH_S:    st = ST_S;
               CH_G:    st = ST_G;
               CH_H:    st = ST_H;
               default: st = ST_BAD;
            endcase
         end else if (st == ST_S) begin
            st = (up == CH_T) ? ST_ST : (up == CH_E) ? ST_SE : ST_BAD;
         end else if (st == ST_SETCMD) begin
            st = (c == CH_SPACE) ? ST_ARGS : ST_BAD;
         end else if (want != '0) begin
            st = (up == want) ? st + 5'd1 : ST_BAD;
         end else begin
            st = ST_BAD;
         end
      end
      line_state = st;
      return has;
   endfunction

   function automatic char_type any_char_but_newline();
      char_type b;
      do b = char_type'($urandom_range(0, 255)); while (b == CH_NL);
      return b;
   endfunction

   // Keyword letters in random case.
   task automatic push_word(input string w);
      char_type c;
      for (int i = 0; i < w.len(); i++) begin
         c = char_type'(w[i]);
         if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
            c = c + 8'h20;
         line_chars.push_back(c);
      end
   endtask

   // Sender: one character per transfer, random idle bursts outside the tail.
   always @(negedge clock) begin
      logic     v;
      char_type d;
      v = req_tvalid;
      d = req_tdata;
      if (reset) begin
         v = 1'b0;
      end else begin
         if (v && char_taken)
            v = 1'b0;
         if (!v) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (line_chars.size() > 0) begin
               if (line_chars.size() > TailChars && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(0, 15);
               end else begin
                  d = line_chars.pop_front();
                  v = 1'b1;
               end
            end
         end
      end
      req_tvalid <= v;
      req_tdata  <= d;
   end

   // Receiver: random stall bursts plus one long hold-off to back up the input.
   always @(negedge clock) begin
      logic r;
      if (hold_left > 0) begin
         hold_left--;
         r = 1'b0;
      end else if (!long_hold_done && results_taken >= 60) begin
         long_hold_done = 1'b1;
         hold_left = LongHold - 1;
         r = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         r = 1'b0;
      end else if (line_chars.size() > TailChars && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 15);
         r = 1'b0;
      end else begin
         r = 1'b1;
      end
      rsp_tready <= r;
   end

   // Monitor and scoreboard.
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      char_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_taken++;
            got.kind = rsp_tuser;
            got.code = rsp_tdata[2:0];
            got.arg  = rsp_tdata[10:3];
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result kind %0d code %0d arg %02h",
                        $time, got.kind, got.code, got.arg);
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind || got.code !== want.code ||
                   got.arg !== want.arg || rsp_tdata[15:11] !== '0) begin
                  errors++;
                  $display({"%0t: expected kind %0d code %0d arg %02h, ",
                            "got kind %0d code %0d arg %02h pad %02h"},
                           $time, want.kind, want.code, want.arg,
                           got.kind, got.code, got.arg, rsp_tdata[15:11]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            char_taken = 1'b1;
            if (parse_char(req_tdata, want))
               pending_results.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      string    w;
      int       pick;
      // empty line, a plain keyword, an argument with zero and high bytes,
      // a high byte inside a keyword, SETCMD without its space
      line_chars.push_back(CH_NL);
      push_word("stats");
      line_chars.push_back(CH_NL);
      push_word("SETCMD");
      line_chars.push_back(CH_SPACE);
      line_chars.push_back(8'h00);
      line_chars.push_back(8'hFF);
      line_chars.push_back("a");
      line_chars.push_back("Z");
      line_chars.push_back(CH_NL);
      push_word("HE");
      line_chars.push_back(8'h80);
      line_chars.push_back(CH_NL);
      push_word("SETCMD");
      line_chars.push_back(CH_NL);

      // mostly well-formed lines, the rest truncated, broken or noise
      while (line_chars.size() < 580) begin
         w = kw_stats;
         case ($urandom_range(0, 4))
            0: w = kw_stats;
            1: w = kw_getcmd;
            2: w = kw_setcmd;
            3: w = kw_logout;
            default: w = kw_help;
         endcase
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            push_word(w);
            if (w == kw_setcmd) begin
               line_chars.push_back(CH_SPACE);
               repeat ($urandom_range(0, 8)) line_chars.push_back(any_char_but_newline());
            end
         end else if (pick == 7) begin
            push_word(w.substr(0, $urandom_range(0, w.len() - 2)));
         end else if (pick == 8) begin
            push_word(w.substr(0, $urandom_range(0, w.len() - 1)));
            repeat ($urandom_range(1, 4)) line_chars.push_back(any_char_but_newline());
         end else begin
            repeat ($urandom_range(0, 6))
               line_chars.push_back(char_type'($urandom_range(0, 255)));
         end
         line_chars.push_back(CH_NL);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (line_chars.size() > 0 || req_tvalid || pending_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
